### rtl/core/gnmbfs_pkg.sv
package gnmbfs_pkg;

    localparam int NODES  = 64;
    localparam int IDX_W  = $clog2(NODES);
    localparam int NODE_W = 6;
    localparam int OPC_W  = 3;
    localparam int DIST_W = 6;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic [OPC_W-1:0] OP_ADD_EDGE = 3'd0;
    localparam logic [OPC_W-1:0] OP_MARK     = 3'd1;
    localparam logic [OPC_W-1:0] OP_QUERY    = 3'd2;
    localparam logic [OPC_W-1:0] OP_ADJ_TEST = 3'd3;
    localparam logic [OPC_W-1:0] OP_CLEAR    = 3'd4;

    typedef enum logic [2:0] {
        K_NOP,
        K_ADD,
        K_MARK,
        K_QUERY,
        K_ADJ,
        K_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic              a_ok;
        logic              b_ok;
        logic [NODE_W-1:0] a;
        logic [NODE_W-1:0] b;
    } t_cmd;

    // Packed so that status lands in the lowest bit.
    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              adjacent;
        logic              status;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_A,
        S_ADD_B,
        S_ADJ,
        S_Q_TEST,
        S_Q_SCAN,
        S_Q_NEXT
    } t_state;

endpackage

### rtl/core/gnmbfs_front.sv
module gnmbfs_front (
    input  logic                         i_valid,
    input  logic [gnmbfs_pkg::OPC_W-1:0]  i_opcode,
    input  logic [gnmbfs_pkg::NODE_W-1:0] i_node_a,
    input  logic [gnmbfs_pkg::NODE_W-1:0] i_node_b,
    input  logic                         i_full,
    output logic                         o_ready,
    output logic                         o_push,
    output gnmbfs_pkg::t_cmd              o_cmd
);

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_cmd.a    = i_node_a;
        o_cmd.b    = i_node_b;
        o_cmd.a_ok = (32'(i_node_a) < gnmbfs_pkg::NODES);
        o_cmd.b_ok = (32'(i_node_b) < gnmbfs_pkg::NODES);
        unique case (i_opcode)
            gnmbfs_pkg::OP_ADD_EDGE: o_cmd.kind = gnmbfs_pkg::K_ADD;
            gnmbfs_pkg::OP_MARK:     o_cmd.kind = gnmbfs_pkg::K_MARK;
            gnmbfs_pkg::OP_QUERY:    o_cmd.kind = gnmbfs_pkg::K_QUERY;
            gnmbfs_pkg::OP_ADJ_TEST: o_cmd.kind = gnmbfs_pkg::K_ADJ;
            gnmbfs_pkg::OP_CLEAR:    o_cmd.kind = gnmbfs_pkg::K_CLEAR;
            default:                 o_cmd.kind = gnmbfs_pkg::K_NOP;
        endcase
    end

endmodule

### rtl/core/gnmbfs_fifo.sv
module gnmbfs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  gnmbfs_pkg::t_cmd i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output gnmbfs_pkg::t_cmd o_data
);

    gnmbfs_pkg::t_cmd r_q [gnmbfs_pkg::Q_DEPTH];
    logic [gnmbfs_pkg::QPTR_W-1:0] r_wp;
    logic [gnmbfs_pkg::QPTR_W-1:0] r_rp;
    logic [gnmbfs_pkg::QCNT_W-1:0] r_cnt;
    logic [gnmbfs_pkg::QPTR_W-1:0] n_wp;
    logic [gnmbfs_pkg::QPTR_W-1:0] n_rp;
    logic [gnmbfs_pkg::QCNT_W-1:0] n_cnt;
    logic                          do_pop;

    assign o_full  = (32'(r_cnt) == gnmbfs_pkg::Q_DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (32'(r_wp) == gnmbfs_pkg::Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (32'(r_rp) == gnmbfs_pkg::Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_data;
        end
    end

endmodule

### rtl/core/gnmbfs_back.sv
module gnmbfs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  gnmbfs_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    output logic             o_res_valid,
    output gnmbfs_pkg::t_res  o_res,
    input  logic             i_res_ready
);

    localparam int N = gnmbfs_pkg::NODES;
    localparam int W = gnmbfs_pkg::IDX_W;
    localparam logic [N-1:0] ONE = N'(1);

    logic [N-1:0] r_mem [N];
    logic [N-1:0] r_row_valid;
    logic [N-1:0] r_rd_data;
    logic         r_rd_vld;

    gnmbfs_pkg::t_state r_state;
    gnmbfs_pkg::t_state n_state;
    logic [N-1:0] r_known,  n_known;
    logic [N-1:0] r_marked, n_marked;
    logic [N-1:0] r_front,  n_front;
    logic [N-1:0] r_visit,  n_visit;
    logic [N-1:0] r_next,   n_next;
    logic [W-1:0] r_a,      n_a;
    logic [W-1:0] r_b,      n_b;
    logic [W-1:0] r_cnt,    n_cnt;
    logic [W-1:0] r_lvl,    n_lvl;
    logic         r_res_valid, n_res_valid;
    gnmbfs_pkg::t_res r_res, n_res;

    logic         pop;
    logic [W-1:0] a_idx;
    logic [W-1:0] b_idx;
    logic         a_known;
    logic [N-1:0] row_eff;
    logic [N-1:0] grow;
    logic [W-1:0] lvl_m1;
    logic [gnmbfs_pkg::DIST_W-1:0] hop_dist;
    logic         scan_last;
    logic         hit;

    logic         rd_en;
    logic [W-1:0] rd_addr;
    logic         wr_en;
    logic [W-1:0] wr_addr;
    logic [N-1:0] wr_data;
    logic         clr_rows;

    assign pop       = (r_state == gnmbfs_pkg::S_IDLE) && i_cmd_valid &&
                       (!r_res_valid || i_res_ready);
    assign o_cmd_pop = pop;
    assign o_res_valid = r_res_valid;
    assign o_res     = r_res;

    assign a_idx     = W'(i_cmd.a);
    assign b_idx     = W'(i_cmd.b);
    assign a_known   = i_cmd.a_ok && r_known[a_idx];
    assign row_eff   = r_rd_vld ? r_rd_data : '0;
    assign grow      = r_next & ~r_visit;
    assign scan_last = (32'(r_cnt) == N - 1);
    assign hit       = ((r_front & r_marked) != '0);
    assign lvl_m1    = r_lvl - W'(1);

    always_comb begin
        if (r_lvl == '0) begin
            hop_dist = '0;
        end else if (32'(lvl_m1) > 32'(gnmbfs_pkg::DIST_MAX)) begin
            hop_dist = gnmbfs_pkg::DIST_MAX;
        end else begin
            hop_dist = gnmbfs_pkg::DIST_W'(lvl_m1);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gnmbfs_pkg::S_IDLE: begin
                if (pop) begin
                    unique case (i_cmd.kind)
                        gnmbfs_pkg::K_ADD: begin
                            if (i_cmd.a_ok && i_cmd.b_ok) begin
                                n_state = gnmbfs_pkg::S_ADD_A;
                            end
                        end
                        gnmbfs_pkg::K_QUERY: begin
                            if (a_known) begin
                                n_state = gnmbfs_pkg::S_Q_TEST;
                            end
                        end
                        gnmbfs_pkg::K_ADJ: begin
                            if (i_cmd.a != i_cmd.b && i_cmd.a_ok && i_cmd.b_ok) begin
                                n_state = gnmbfs_pkg::S_ADJ;
                            end
                        end
                        default: n_state = gnmbfs_pkg::S_IDLE;
                    endcase
                end
            end
            gnmbfs_pkg::S_ADD_A: n_state = gnmbfs_pkg::S_ADD_B;
            gnmbfs_pkg::S_ADD_B: n_state = gnmbfs_pkg::S_IDLE;
            gnmbfs_pkg::S_ADJ:   n_state = gnmbfs_pkg::S_IDLE;
            gnmbfs_pkg::S_Q_TEST: begin
                n_state = hit ? gnmbfs_pkg::S_IDLE : gnmbfs_pkg::S_Q_SCAN;
            end
            gnmbfs_pkg::S_Q_SCAN: begin
                if (scan_last) begin
                    n_state = gnmbfs_pkg::S_Q_NEXT;
                end
            end
            gnmbfs_pkg::S_Q_NEXT: begin
                n_state = (grow == '0) ? gnmbfs_pkg::S_IDLE : gnmbfs_pkg::S_Q_TEST;
            end
            default: n_state = gnmbfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_known     = r_known;
        n_marked    = r_marked;
        n_front     = r_front;
        n_visit     = r_visit;
        n_next      = r_next;
        n_a         = r_a;
        n_b         = r_b;
        n_cnt       = r_cnt;
        n_lvl       = r_lvl;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        rd_en       = 1'b0;
        rd_addr     = r_a;
        wr_en       = 1'b0;
        wr_addr     = r_a;
        wr_data     = row_eff;
        clr_rows    = 1'b0;

        unique case (r_state)
            gnmbfs_pkg::S_IDLE: begin
                if (pop) begin
                    n_a = a_idx;
                    n_b = b_idx;
                    n_res = '0;
                    n_res_valid = 1'b1;
                    unique case (i_cmd.kind)
                        gnmbfs_pkg::K_ADD: begin
                            if (i_cmd.a_ok && i_cmd.b_ok) begin
                                n_res_valid = 1'b0;
                                rd_en = 1'b1;
                                rd_addr = a_idx;
                            end
                        end
                        gnmbfs_pkg::K_MARK: begin
                            if (a_known) begin
                                n_marked[a_idx] = 1'b1;
                            end else begin
                                n_res.status = 1'b1;
                            end
                        end
                        gnmbfs_pkg::K_QUERY: begin
                            if (a_known) begin
                                n_res_valid = 1'b0;
                                n_front = ONE << a_idx;
                                n_visit = ONE << a_idx;
                                n_lvl = '0;
                            end else begin
                                n_res.status = 1'b1;
                            end
                        end
                        gnmbfs_pkg::K_ADJ: begin
                            if (i_cmd.a == i_cmd.b) begin
                                n_res.adjacent = 1'b1;
                            end else if (i_cmd.a_ok && i_cmd.b_ok) begin
                                n_res_valid = 1'b0;
                                rd_en = 1'b1;
                                rd_addr = a_idx;
                            end
                        end
                        gnmbfs_pkg::K_CLEAR: begin
                            n_known = '0;
                            n_marked = '0;
                            clr_rows = 1'b1;
                        end
                        default: n_res = '0;
                    endcase
                end
            end
            gnmbfs_pkg::S_ADD_A: begin
                wr_en = 1'b1;
                wr_addr = r_a;
                wr_data = row_eff | (ONE << r_b);
                rd_en = 1'b1;
                rd_addr = r_b;
            end
            gnmbfs_pkg::S_ADD_B: begin
                wr_en = 1'b1;
                wr_addr = r_b;
                wr_data = row_eff | (ONE << r_a);
                n_known[r_a] = 1'b1;
                n_known[r_b] = 1'b1;
                n_marked[r_a] = 1'b0;
                n_marked[r_b] = 1'b0;
                n_res = '0;
                n_res_valid = 1'b1;
            end
            gnmbfs_pkg::S_ADJ: begin
                n_res = '0;
                n_res.adjacent = row_eff[r_b];
                n_res_valid = 1'b1;
            end
            gnmbfs_pkg::S_Q_TEST: begin
                if (hit) begin
                    n_res = '0;
                    n_res.found = 1'b1;
                    n_res.distance = hop_dist;
                    n_res_valid = 1'b1;
                end else begin
                    rd_en = 1'b1;
                    rd_addr = '0;
                    n_cnt = '0;
                    n_next = '0;
                end
            end
            gnmbfs_pkg::S_Q_SCAN: begin
                rd_en = 1'b1;
                rd_addr = r_cnt + W'(1);
                if (r_front[r_cnt]) begin
                    n_next = r_next | row_eff;
                end
                if (!scan_last) begin
                    n_cnt = r_cnt + W'(1);
                end
            end
            gnmbfs_pkg::S_Q_NEXT: begin
                if (grow == '0) begin
                    n_res = '0;
                    n_res_valid = 1'b1;
                end else begin
                    n_front = grow;
                    n_visit = r_visit | grow;
                    n_lvl = r_lvl + W'(1);
                end
            end
            default: n_res_valid = r_res_valid && !i_res_ready;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gnmbfs_pkg::S_IDLE;
            r_res_valid <= 1'b0;
            r_known     <= '0;
            r_marked    <= '0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
            r_known     <= n_known;
            r_marked    <= n_marked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_visit <= n_visit;
        r_next  <= n_next;
        r_a     <= n_a;
        r_b     <= n_b;
        r_cnt   <= n_cnt;
        r_lvl   <= n_lvl;
        r_res   <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (clr_rows) begin
            r_row_valid <= '0;
        end else if (wr_en) begin
            r_row_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_valid[rd_addr];
        end
    end

endmodule

### rtl/core/graph_nearest_marked_node_bfs_unit.sv
// Mark, clear, no-op and bad-index words are answered from the idle state; an adjacency test
// reads the row of the first node, and edge insertion updates the rows of both ends in turn.
// A query searches breadth-first level by level, each level a scan that reads one
// adjacency row per cycle from the row memory.
// Words wait in the input queue while the back end works on an earlier one.
// Synchronous active-low reset empties the graph, the queue and the output register.
module graph_nearest_marked_node_bfs_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // node_a [5:0], node_b [11:6], zeros above.
    input  logic [gnmbfs_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // opcode [2:0].
    input  logic [gnmbfs_pkg::OPC_W-1:0]          i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // status [0], adjacent [1], found [2], distance [8:3], zeros above.
    output logic [gnmbfs_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int RES_W = $bits(gnmbfs_pkg::t_res);

    gnmbfs_pkg::t_cmd front_cmd;
    gnmbfs_pkg::t_cmd q_cmd;
    gnmbfs_pkg::t_res res;
    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    gnmbfs_front u_front (
        .i_valid  (i_s_axis_tvalid),
        .i_opcode (i_s_axis_tuser),
        .i_node_a (i_s_axis_tdata[gnmbfs_pkg::NODE_W-1:0]),
        .i_node_b (i_s_axis_tdata[2*gnmbfs_pkg::NODE_W-1:gnmbfs_pkg::NODE_W]),
        .i_full   (q_full),
        .o_ready  (o_s_axis_tready),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    gnmbfs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_cmd)
    );

    gnmbfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_res_valid (o_m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {{(gnmbfs_pkg::OUT_TDATA_W - RES_W){1'b0}}, res};

endmodule

### rtl/core/gnmbfs_checker.sv
module gnmbfs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result word changed while stalled");

    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[1] && o_m_axis_tdata[2]))
        else $error("adjacency and query answers set together");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[2] || o_m_axis_tdata[1]) |->
            !o_m_axis_tdata[0])
        else $error("answer given with error status");

    a_dist_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[8:3] != 6'd0) |-> o_m_axis_tdata[2])
        else $error("distance without a found node");

endmodule

bind graph_nearest_marked_node_bfs_unit gnmbfs_checker u_gnmbfs_checker (.*);

### sim/tb_graph_nearest_marked_node_bfs_unit.sv
module tb_graph_nearest_marked_node_bfs_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ITEM_TARGET  = 1150;
    localparam int          CYCLE_LIMIT  = 10000000;
    localparam int          SETTLE_TICKS = 8;
    localparam int          REPORT_MAX   = 10;
    localparam logic [2:0]  OP_IDLE_LO   = 3'd5;
    localparam logic [2:0]  OP_IDLE_HI   = 3'd7;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [gnmbfs_pkg::IN_TDATA_W-1:0]   s_tdata = '0;
    logic [gnmbfs_pkg::OPC_W-1:0]        s_tuser = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [gnmbfs_pkg::OUT_TDATA_W-1:0]  m_tdata;

    logic [gnmbfs_pkg::NODES-1:0] link_rows [gnmbfs_pkg::NODES];
    logic [gnmbfs_pkg::NODES-1:0] known_set;
    logic [gnmbfs_pkg::NODES-1:0] marked_set;
    gnmbfs_pkg::t_res             awaited_answers [$];

    int  words_sent = 0;
    int  mismatches = 0;
    int  cycle_count = 0;
    int  stall_left = 0;
    int  hold_request = 0;
    int  roll;
    bit  sender_idle = 1'b1;
    bit  receiver_idle = 1'b1;

    graph_nearest_marked_node_bfs_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long stretch when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!receiver_idle) begin
            m_tready <= 1'b1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(15, 60);
            end
        end
    end

    function automatic void wipe_graph();
        for (int n = 0; n < gnmbfs_pkg::NODES; n++) begin
            link_rows[n] = '0;
        end
        known_set = '0;
        marked_set = '0;
    endfunction

    // Level of the nearest marked node reachable from start, or -1 if none.
    function automatic int nearest_marked_level(input int start);
        logic [gnmbfs_pkg::NODES-1:0] seen;
        logic [gnmbfs_pkg::NODES-1:0] front;
        logic [gnmbfs_pkg::NODES-1:0] reach;
        int                           lvl;
        seen = '0;
        seen[start] = 1'b1;
        front = seen;
        lvl = 0;
        while (1) begin
            if ((front & marked_set) != '0) begin
                return lvl;
            end
            reach = '0;
            for (int n = 0; n < gnmbfs_pkg::NODES; n++) begin
                if (front[n]) begin
                    reach |= link_rows[n];
                end
            end
            reach &= ~seen;
            seen |= reach;
            if (reach == '0) begin
                return -1;
            end
            front = reach;
            lvl++;
        end
    endfunction

    function automatic gnmbfs_pkg::t_res apply_graph_op(
            input logic [gnmbfs_pkg::OPC_W-1:0]  op,
            input logic [gnmbfs_pkg::NODE_W-1:0] a,
            input logic [gnmbfs_pkg::NODE_W-1:0] b);
        gnmbfs_pkg::t_res res;
        bit               a_ok;
        bit               b_ok;
        int               lvl;
        res = '0;
        a_ok = int'(a) < gnmbfs_pkg::NODES;
        b_ok = int'(b) < gnmbfs_pkg::NODES;
        case (op)
            gnmbfs_pkg::OP_ADD_EDGE: begin
                if (a_ok && b_ok) begin
                    link_rows[a][b] = 1'b1;
                    link_rows[b][a] = 1'b1;
                    known_set[a] = 1'b1;
                    known_set[b] = 1'b1;
                    marked_set[a] = 1'b0;
                    marked_set[b] = 1'b0;
                end
            end
            gnmbfs_pkg::OP_MARK: begin
                if (a_ok && known_set[a]) begin
                    marked_set[a] = 1'b1;
                end else begin
                    res.status = 1'b1;
                end
            end
            gnmbfs_pkg::OP_QUERY: begin
                if (a_ok && known_set[a]) begin
                    lvl = nearest_marked_level(a);
                    if (lvl >= 0) begin
                        res.found = 1'b1;
                        if (lvl == 0) begin
                            res.distance = '0;
                        end else if (lvl - 1 > int'(gnmbfs_pkg::DIST_MAX)) begin
                            res.distance = gnmbfs_pkg::DIST_MAX;
                        end else begin
                            res.distance = gnmbfs_pkg::DIST_W'(lvl - 1);
                        end
                    end
                end else begin
                    res.status = 1'b1;
                end
            end
            gnmbfs_pkg::OP_ADJ_TEST: begin
                if (a == b) begin
                    res.adjacent = 1'b1;
                end else if (a_ok && b_ok && link_rows[a][b]) begin
                    res.adjacent = 1'b1;
                end
            end
            gnmbfs_pkg::OP_CLEAR: begin
                wipe_graph();
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!sender_idle) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [gnmbfs_pkg::NODE_W-1:0] any_node();
        return gnmbfs_pkg::NODE_W'($urandom_range(0, 63));
    endfunction

    task automatic send_word(input logic [gnmbfs_pkg::OPC_W-1:0] op,
                             input logic [gnmbfs_pkg::NODE_W-1:0] a,
                             input logic [gnmbfs_pkg::NODE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {{(gnmbfs_pkg::IN_TDATA_W - 2 * gnmbfs_pkg::NODE_W){1'b0}}, b, a};
        do @(negedge i_clk); while (!s_tready);
        @(posedge i_clk);
        awaited_answers.push_back(apply_graph_op(op, a, b));
        words_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (awaited_answers.size() != 0);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input int exp_val, input int act_val);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch in %s: expected %0d, got %0d", what, exp_val, act_val);
        end
    endtask

    // Output and ready only change at rising edges, so the falling edge sees a stable handshake.
    always @(negedge i_clk) begin
        gnmbfs_pkg::t_res got;
        gnmbfs_pkg::t_res want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = gnmbfs_pkg::t_res'(m_tdata[$bits(gnmbfs_pkg::t_res)-1:0]);
            if (awaited_answers.size() == 0) begin
                note_mismatch("unexpected result word", 0, int'(m_tdata));
            end else begin
                want = awaited_answers.pop_front();
                if (got.status !== want.status) begin
                    note_mismatch("status", want.status, got.status);
                end
                if (got.adjacent !== want.adjacent) begin
                    note_mismatch("adjacent", want.adjacent, got.adjacent);
                end
                if (got.found !== want.found) begin
                    note_mismatch("found", want.found, got.found);
                end
                if (got.distance !== want.distance) begin
                    note_mismatch("distance", want.distance, got.distance);
                end
            end
        end
    end

    task automatic test_directed_ops();
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd0);
        send_word(gnmbfs_pkg::OP_MARK, 6'd63, 6'd0);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd5, 6'd5);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd0, 6'd63);
        send_word(gnmbfs_pkg::OP_ADD_EDGE, 6'd0, 6'd63);
        send_word(gnmbfs_pkg::OP_ADD_EDGE, 6'd42, 6'd42);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd63, 6'd0);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd42, 6'd42);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd63);
        send_word(gnmbfs_pkg::OP_MARK, 6'd63, 6'd63);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd63, 6'd0);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd0);
        send_word(gnmbfs_pkg::OP_ADD_EDGE, 6'd63, 6'd21);
        send_word(gnmbfs_pkg::OP_MARK, 6'd21, 6'd0);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd0);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd42, 6'd0);
        for (int op = OP_IDLE_LO; op <= OP_IDLE_HI; op++) begin
            send_word(gnmbfs_pkg::OPC_W'(op), 6'd63, 6'd63);
        end
        send_word(gnmbfs_pkg::OP_CLEAR, 6'd63, 6'd63);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd0);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd0, 6'd63);
        send_word(gnmbfs_pkg::OP_MARK, 6'd21, 6'd0);
    endtask

    task automatic test_full_output_stall();
        sender_idle = 1'b0;
        hold_request = 400;
        for (int i = 0; i < 12; i++) begin
            send_word(gnmbfs_pkg::OP_ADD_EDGE, 6'(i), 6'(i + 1));
            send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'(i + 1), 6'(i));
        end
        send_word(gnmbfs_pkg::OP_MARK, 6'd12, 6'd0);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd0, 6'd0);
        sender_idle = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_word(gnmbfs_pkg::OP_ADD_EDGE, 6'd30, 6'd31);
        send_word(gnmbfs_pkg::OP_MARK, 6'd31, 6'd0);
        send_word(gnmbfs_pkg::OP_QUERY, 6'd30, 6'd0);
        wait_drained();
        send_word(gnmbfs_pkg::OP_QUERY, 6'd31, 6'd0);
        send_word(gnmbfs_pkg::OP_ADJ_TEST, 6'd31, 6'd30);
        wait_drained();
    endtask

    task automatic test_random_graphs();
        logic [gnmbfs_pkg::NODE_W-1:0] order [gnmbfs_pkg::NODES];
        logic [gnmbfs_pkg::NODE_W-1:0] swap;
        int                            pool;
        int                            i;
        int                            j;
        while (words_sent < ITEM_TARGET) begin
            sender_idle = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0) begin
                send_word(gnmbfs_pkg::OP_CLEAR, any_node(), any_node());
            end
            for (i = 0; i < gnmbfs_pkg::NODES; i++) begin
                order[i] = gnmbfs_pkg::NODE_W'(i);
            end
            for (i = gnmbfs_pkg::NODES - 1; i > 0; i--) begin
                j = $urandom_range(0, i);
                swap = order[i];
                order[i] = order[j];
                order[j] = swap;
            end
            pool = ($urandom_range(0, 14) == 0) ? $urandom_range(20, gnmbfs_pkg::NODES)
                                                 : $urandom_range(2, 12);
            if ($urandom_range(0, 1) == 0) begin
                for (i = 0; i + 1 < pool; i++) begin
                    if ($urandom_range(0, 1) == 0) begin
                        send_word(gnmbfs_pkg::OP_ADD_EDGE, order[i], order[i + 1]);
                    end else begin
                        send_word(gnmbfs_pkg::OP_ADD_EDGE, order[i + 1], order[i]);
                    end
                end
                if ($urandom_range(0, 1) == 0) begin
                    send_word(gnmbfs_pkg::OP_MARK, order[pool - 1], any_node());
                    send_word(gnmbfs_pkg::OP_QUERY, order[0], any_node());
                end
            end else begin
                repeat (pool + $urandom_range(0, pool / 2)) begin
                    send_word(gnmbfs_pkg::OP_ADD_EDGE, order[$urandom_range(0, pool - 1)],
                              order[$urandom_range(0, pool - 1)]);
                end
            end
            repeat ($urandom_range(0, 3)) begin
                send_word(gnmbfs_pkg::OP_MARK, order[$urandom_range(0, pool - 1)],
                          any_node());
            end
            if ($urandom_range(0, 3) == 0) begin
                send_word(gnmbfs_pkg::OP_MARK, any_node(), any_node());
            end
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 5) == 0) begin
                    send_word(gnmbfs_pkg::OP_QUERY, any_node(), any_node());
                end else begin
                    send_word(gnmbfs_pkg::OP_QUERY, order[$urandom_range(0, pool - 1)],
                              any_node());
                end
            end
            repeat ($urandom_range(0, 2)) begin
                send_word(gnmbfs_pkg::OP_ADJ_TEST, order[$urandom_range(0, pool - 1)],
                          order[$urandom_range(0, pool - 1)]);
            end
            repeat ($urandom_range(0, 2)) begin
                send_word(gnmbfs_pkg::OPC_W'($urandom_range(0, 7)), any_node(), any_node());
            end
        end
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
    endtask

    initial begin
        wipe_graph();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_ops();
        test_full_output_stall();
        test_drain_pause();
        test_random_graphs();

        wait_drained();
        if (mismatches == 0 && awaited_answers.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/gnmbfs_pkg.sv
rtl/core/gnmbfs_front.sv
rtl/core/gnmbfs_fifo.sv
rtl/core/gnmbfs_back.sv
rtl/core/graph_nearest_marked_node_bfs_unit.sv
rtl/core/gnmbfs_checker.sv
sim/tb_graph_nearest_marked_node_bfs_unit.sv
